// ===== rtl/multi_channel_countdown_timer_macros.svh =====
// assertion macros for the countdown timer bank
`ifndef MULTI_CHANNEL_COUNTDOWN_TIMER_MACROS_SVH
`define MULTI_CHANNEL_COUNTDOWN_TIMER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define MCDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define MCDT_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) cond |=> nxt) else $error(msg);

`else

`define MCDT_ASSERT(lbl, prop, msg)

`define MCDT_ASSERT_NEXT(lbl, cond, nxt, msg)

`endif

`endif

// ===== rtl/mcdt_pkg.sv =====
// types and constants shared by the countdown timer bank
`timescale 1ns / 1ps
`default_nettype none

package mcdt_pkg;

  localparam int unsigned NS_W = 63;

  localparam logic [29:0] NS_PER_S  = 30'd1000000000;
  localparam logic [9:0]  NS_PER_US = 10'd1000;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_ARM     = 2'd1,
    ACT_DISARM  = 2'd2,
    ACT_READ    = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    KIND_DONE  = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_CLOCK = 2'd2
  } kind_t;

  localparam logic [1:0] CLK_MONO = 2'd0;
  localparam logic [1:0] CLK_REAL = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_READ
  } state_t;

  // tick wave that travels down the slot chain
  typedef struct packed {
    logic            valid;
    logic [NS_W-1:0] amount;
  } wave_t;

  // slot write command, applied to the selected cell
  typedef struct packed {
    logic            arm;
    logic            disarm;
    logic [NS_W-1:0] amount;
    logic [NS_W-1:0] period;
  } slot_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/mcdt_cell.sv =====
// one timer slot of the chain: countdown, period and armed flag
`timescale 1ns / 1ps
`default_nettype none

module mcdt_cell (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 sel,
  input  wire mcdt_pkg::slot_cmd_t  cmd,
  input  wire mcdt_pkg::wave_t      wave_in,
  output mcdt_pkg::wave_t           wave_out,
  output logic                      fire
);

  logic [mcdt_pkg::NS_W-1:0] remaining;
  logic [mcdt_pkg::NS_W-1:0] period;
  logic                      armed;
  logic                      wave_vld;
  logic [mcdt_pkg::NS_W-1:0] wave_amt;

  assign fire     = wave_in.valid && armed && (remaining <= wave_in.amount);
  assign wave_out = '{valid: wave_vld, amount: wave_amt};

  always_ff @(posedge clk) begin
    if (rst) begin
      armed    <= 1'b0;
      wave_vld <= 1'b0;
    end else begin
      if (cmd.arm && sel) begin
        armed <= 1'b1;
      end else if (cmd.disarm && sel) begin
        armed <= 1'b0;
      end else if (en && fire && (period == '0)) begin
        armed <= 1'b0;
      end
      if (en) begin
        wave_vld <= wave_in.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.arm && sel) begin
      remaining <= cmd.amount;
      period    <= cmd.period;
    end else if (cmd.disarm && sel) begin
      remaining <= '0;
      period    <= '0;
    end else if (en && wave_in.valid && armed) begin
      if (fire) begin
        // one-shot keeps zero, periodic reloads
        remaining <= period;
      end else begin
        remaining <= remaining - wave_in.amount;
      end
    end
    if (en) begin
      wave_amt <= wave_in.amount;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/multi_channel_countdown_timer.sv =====
// top level of the countdown timer bank: control, clocks and slot chain
//
//   channel  | signals                      | direction
//   ---------+------------------------------+----------
//   in       | in_valid / in_ready + fields | into block
//   out      | out_valid / out_ready        | out of block
//   cfg      | cfg_write / cfg_data         | into block
//
// a tick sends a wave down the slot chain, one cell per cycle while the
// output is free, giving one transfer per fired slot and a final done
// transfer. arm and disarm reply from idle, a read from the read state.
// a full output stalls the wave in place. reset disarms all slots
// and clears both clocks; a new item waits until the previous one is done.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_channel_countdown_timer_macros.svh"

module multi_channel_countdown_timer #(
  parameter int TIMER_SLOTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [2:0]  slot_index,
  input  wire logic [62:0] amount_ns,
  input  wire logic [62:0] period_ns,
  input  wire logic [1:0]  clock_select,
  input  wire logic [15:0] since_tick_us,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [2:0]       fired_slot,
  output logic [63:0]      clock_value_ns,
  output logic             last,
  input  wire logic        cfg_write,
  input  wire logic [31:0] cfg_data
);

  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

  mcdt_pkg::state_t          state;
  mcdt_pkg::state_t          state_next;
  logic [CNT_W-1:0]          cnt;
  logic [mcdt_pkg::NS_W-1:0] tick_amt;
  logic [63:0]               mono;
  logic [61:0]               epoch_ns;
  logic                      rd_ok;
  logic                      rd_real;
  logic [25:0]               rd_extra;

  logic                      out_free;
  logic                      in_fire;
  logic                      adv;
  logic                      load;
  mcdt_pkg::kind_t           res_kind;
  logic [2:0]                res_slot;
  logic [63:0]               res_val;
  logic                      res_last;
  logic [63:0]               read_sum;

  mcdt_pkg::act_t            act;
  mcdt_pkg::slot_cmd_t       cmd;
  mcdt_pkg::wave_t           wave [TIMER_SLOTS+1];
  logic [TIMER_SLOTS:0]      wave_vld;
  logic [TIMER_SLOTS-1:0]    fire_vec;
  logic [TIMER_SLOTS-1:0]    sel_vec;

  assign act      = mcdt_pkg::act_t'(action);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == mcdt_pkg::ST_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;

  assign cmd = '{arm:    in_fire && (act == mcdt_pkg::ACT_ARM),
                 disarm: in_fire && (act == mcdt_pkg::ACT_DISARM),
                 amount: amount_ns,
                 period: period_ns};

  assign wave[0] = '{valid: (state == mcdt_pkg::ST_TICK) && (cnt == '0),
                     amount: tick_amt};

  assign read_sum = mono + (rd_real ? {2'b00, epoch_ns} : 64'd0) + {38'd0, rd_extra};

  genvar g;
  generate
    for (g = 0; g < TIMER_SLOTS; g++) begin : g_slot
      assign sel_vec[g] = (int'(slot_index) == g);
      mcdt_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .en       (adv),
        .sel      (sel_vec[g]),
        .cmd      (cmd),
        .wave_in  (wave[g]),
        .wave_out (wave[g+1]),
        .fire     (fire_vec[g])
      );
    end
    for (g = 0; g <= TIMER_SLOTS; g++) begin : g_vld
      assign wave_vld[g] = wave[g].valid;
    end
  endgenerate

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mcdt_pkg::ST_IDLE: begin
        if (in_fire && (act == mcdt_pkg::ACT_TICK)) begin
          state_next = mcdt_pkg::ST_TICK;
        end else if (in_fire && (act == mcdt_pkg::ACT_READ)) begin
          state_next = mcdt_pkg::ST_READ;
        end
      end
      mcdt_pkg::ST_TICK: begin
        if (out_free && wave[TIMER_SLOTS].valid) begin
          state_next = mcdt_pkg::ST_IDLE;
        end
      end
      mcdt_pkg::ST_READ: begin
        if (out_free) begin
          state_next = mcdt_pkg::ST_IDLE;
        end
      end
      default: state_next = mcdt_pkg::ST_IDLE;
    endcase
  end

  // result selection
  always_comb begin
    adv      = 1'b0;
    load     = 1'b0;
    res_kind = mcdt_pkg::KIND_DONE;
    res_slot = 3'd0;
    res_val  = 64'd0;
    res_last = 1'b0;
    case (state)
      mcdt_pkg::ST_IDLE: begin
        if (cmd.arm || cmd.disarm) begin
          load     = 1'b1;
          res_last = 1'b1;
        end
      end
      mcdt_pkg::ST_TICK: begin
        adv = out_free;
        if (out_free && wave[TIMER_SLOTS].valid) begin
          load     = 1'b1;
          res_last = 1'b1;
        end else if (out_free && (|fire_vec)) begin
          load     = 1'b1;
          res_kind = mcdt_pkg::KIND_FIRED;
          res_slot = 3'(cnt);
        end
      end
      mcdt_pkg::ST_READ: begin
        if (out_free) begin
          load     = 1'b1;
          res_kind = mcdt_pkg::KIND_CLOCK;
          res_val  = rd_ok ? read_sum : 64'd0;
          res_last = 1'b1;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mcdt_pkg::ST_IDLE;
      cnt       <= '0;
      mono      <= 64'd0;
      epoch_ns  <= 62'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire && (act == mcdt_pkg::ACT_TICK)) begin
        cnt  <= '0;
        mono <= mono + {1'b0, amount_ns};
      end else if (adv) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cfg_write) begin
        epoch_ns <= 62'(cfg_data) * 62'(mcdt_pkg::NS_PER_S);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      tick_amt <= amount_ns;
      rd_ok    <= (clock_select == mcdt_pkg::CLK_MONO) ||
                  (clock_select == mcdt_pkg::CLK_REAL);
      rd_real  <= (clock_select == mcdt_pkg::CLK_REAL);
      rd_extra <= 26'(since_tick_us) * 26'(mcdt_pkg::NS_PER_US);
    end
    if (load) begin
      kind           <= res_kind;
      fired_slot     <= res_slot;
      clock_value_ns <= res_val;
      last           <= res_last;
    end
  end

  `MCDT_ASSERT(a_one_wave, $onehot0(wave_vld), "more than one tick wave in the chain")
  `MCDT_ASSERT(a_end_no_fire, !(wave_vld[TIMER_SLOTS] && (|fire_vec)), "fire at wave end")
  `MCDT_ASSERT_NEXT(a_tick_scan, in_fire && (act == mcdt_pkg::ACT_TICK), state == mcdt_pkg::ST_TICK, "tick did not start scan")
  `MCDT_ASSERT_NEXT(a_stall_hold, (state == mcdt_pkg::ST_TICK) && !out_free, $stable(cnt), "scan moved while stalled")

endmodule

`default_nettype wire
